### src/mtp_pkg.sv
// Package for the constant-acceleration time-at-position solver.
// Holds default word sizes and the tolerance register layout; no dependencies.
package mtp_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int TOL_BITS      = 17;
  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(1);

endpackage

### src/motion_time_at_position_top.sv
// Time-at-position solver: deep pipeline with a bit-per-stage square root and
// two bit-per-stage restoring dividers. Depends on mtp_pkg.
//
// channel   | dir | fields (low bit first)
// s_axis    | in  | tdata: seg_time, seg_position, seg_velocity, seg_accel, target_position
// m_axis    | out | tdata: arrival_time; tuser: found
// tol_wr    | in  | tolerance (17 bits)
//
// The pipeline holds WORD_BITS+1 square root stages and WORD_BITS+1 divider
// stages. One beat enters every cycle while the output beat is not stalled.
// A stalled output beat freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits and loads tolerance with 1.
module motion_time_at_position_top #(
  parameter int WORD_BITS = mtp_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = mtp_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  tol_wr_en,
  input  logic [mtp_pkg::TOL_BITS-1:0]          tol_wr_data,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // seg_time, seg_position, seg_velocity, seg_accel, target_position
  input  logic [8*((5*WORD_BITS+7)/8)-1:0]      s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // arrival_time
  output logic [8*((WORD_BITS+7)/8)-1:0]        m_axis_tdata,
  // found
  output logic [0:0]                            m_axis_tuser
);
  import mtp_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int RW   = 2*W + 2;
  localparam int SN   = W + 1;
  localparam int REMW = SN + 2;
  localparam int NW   = W + 1;
  localparam int MW   = NW + F;
  localparam int CW   = MW + W;
  localparam int QW   = W + 1;
  localparam int OW   = 8*((W+7)/8);

  typedef struct packed {
    logic signed [W-1:0] t;
    logic signed [W-1:0] v;
    logic [W-1:0]        magv;
    logic [W-1:0]        maga;
    logic [W:0]          magd;
    logic                a_neg;
    logic                ad_neg;
    logic                there;
    logic                lin;
    logic                lin_ok;
    logic                ok;
    logic                nn1;
    logic                nn2;
  } meta_t;

  logic [TOL_BITS-1:0] tol;
  logic ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (tol_wr_en) begin
      tol <= tol_wr_data;
    end
  end

  assign ce = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  // input decode
  logic signed [W-1:0] in_t, in_p, in_v, in_a, in_x;
  logic signed [W:0]   in_d;
  logic [W:0]          in_magd, tolx;
  logic [W-1:0]        in_magv, in_maga;
  logic                in_opp;
  meta_t               in_meta;

  assign in_t = s_axis_tdata[W-1:0];
  assign in_p = s_axis_tdata[2*W-1:W];
  assign in_v = s_axis_tdata[3*W-1:2*W];
  assign in_a = s_axis_tdata[4*W-1:3*W];
  assign in_x = s_axis_tdata[5*W-1:4*W];
  assign in_d = {in_x[W-1], in_x} - {in_p[W-1], in_p};
  assign in_magd = in_d[W] ? ((~in_d) + (W+1)'(1)) : in_d;
  assign in_magv = in_v[W-1] ? ((~in_v) + W'(1)) : in_v;
  assign in_maga = in_a[W-1] ? ((~in_a) + W'(1)) : in_a;
  assign tolx = (W+1)'(tol);
  assign in_opp = (in_d[W] && !in_v[W-1] && (in_v != '0)) ||
                  (!in_d[W] && (in_d != '0) && in_v[W-1]);

  always_comb begin
    in_meta        = '0;
    in_meta.t      = in_t;
    in_meta.v      = in_v;
    in_meta.magv   = in_magv;
    in_meta.maga   = in_maga;
    in_meta.magd   = in_magd;
    in_meta.a_neg  = in_a[W-1];
    in_meta.ad_neg = (in_d != '0) && (in_a[W-1] != in_d[W]);
    in_meta.there  = in_magd < tolx;
    in_meta.lin    = ({1'b0, in_maga} < tolx) || (in_a == '0);
    in_meta.lin_ok = ({1'b0, in_magv} > tolx) && !in_opp;
  end

  // stage 0: decoded beat
  logic  vld0;
  meta_t meta0;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (ce) begin
      vld0 <= s_axis_tvalid;
    end
    if (ce) begin
      meta0 <= in_meta;
    end
  end

  // stage 1: products
  logic          vld1;
  meta_t         meta1;
  logic [2*W-1:0] v2;
  logic [2*W:0]   adp;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (ce) begin
      vld1 <= vld0;
    end
    if (ce) begin
      meta1 <= meta0;
      v2    <= meta0.magv * meta0.magv;
      adp   <= (2*W+1)'(meta0.maga) * (2*W+1)'(meta0.magd);
    end
  end

  // stage 2: discriminant, lands in square root slot 0
  logic [RW-1:0]   sq_rad  [SN+1];
  logic [REMW-1:0] sq_rem  [SN+1];
  logic [SN-1:0]   sq_root [SN+1];
  meta_t           sq_meta [SN+1];
  logic            sq_vld  [SN+1];

  logic [RW-1:0] v2x, ad2, disc;
  logic          disc_ok;
  meta_t         meta2;
  assign v2x = RW'(v2);
  assign ad2 = {adp, 1'b0};
  always_comb begin
    disc_ok = 1'b1;
    disc    = '0;
    if (!meta1.ad_neg) begin
      disc = v2x + ad2;
    end else if (v2x < ad2) begin
      disc_ok = 1'b0;
    end else begin
      disc = v2x - ad2;
    end
    meta2    = meta1;
    meta2.ok = disc_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (ce) begin
      sq_vld[0] <= vld1;
    end
    if (ce) begin
      sq_rad[0]  <= disc;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_meta[0] <= meta2;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 1; k <= SN; k++) begin : g_sqrt
    logic [REMW-1:0] rs, tr;
    assign rs = {sq_rem[k-1][REMW-3:0], sq_rad[k-1][RW-1:RW-2]};
    assign tr = {sq_root[k-1], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k] <= 1'b0;
      end else if (ce) begin
        sq_vld[k] <= sq_vld[k-1];
      end
      if (ce) begin
        sq_rad[k]  <= sq_rad[k-1] << 2;
        sq_meta[k] <= sq_meta[k-1];
        if (rs >= tr) begin
          sq_rem[k]  <= rs - tr;
          sq_root[k] <= {sq_root[k-1][SN-2:0], 1'b1};
        end else begin
          sq_rem[k]  <= rs;
          sq_root[k] <= {sq_root[k-1][SN-2:0], 1'b0};
        end
      end
    end
  end

  // roots stage: numerators and divider operands
  logic signed [W+2:0] r_n1, r_n2, r_sq, r_vx;
  logic [NW-1:0]       r_m1, r_m2;
  meta_t               r_meta_in;
  logic [NW-1:0]       r_num [2];
  logic [W-1:0]        r_den [2];
  meta_t               r_meta;
  logic                r_vld;

  assign r_sq = $signed({2'b00, sq_root[SN]});
  assign r_vx = (W+3)'(sq_meta[SN].v);
  assign r_n1 = r_sq - r_vx;
  assign r_n2 = -r_vx - r_sq;
  assign r_m1 = NW'(r_n1[W+2] ? -r_n1 : r_n1);
  assign r_m2 = NW'(r_n2[W+2] ? -r_n2 : r_n2);

  always_comb begin
    r_meta_in     = sq_meta[SN];
    r_meta_in.nn1 = (r_n1 == '0) || (r_n1[W+2] == sq_meta[SN].a_neg);
    r_meta_in.nn2 = (r_n2 == '0) || (r_n2[W+2] == sq_meta[SN].a_neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else if (ce) begin
      r_vld <= sq_vld[SN];
    end
    if (ce) begin
      r_meta   <= r_meta_in;
      r_num[0] <= sq_meta[SN].lin ? sq_meta[SN].magd : r_m1;
      r_den[0] <= sq_meta[SN].lin ? sq_meta[SN].magv : sq_meta[SN].maga;
      r_num[1] <= r_m2;
      r_den[1] <= sq_meta[SN].maga;
    end
  end

  // dividers: slot 0 holds the overflow check, then one quotient bit per stage
  logic [MW-1:0] dv_rem   [W+1][2];
  logic [W-1:0]  dv_den   [W+1][2];
  logic [W-1:0]  dv_q     [W+1][2];
  logic          dv_clamp [W+1][2];
  meta_t         dv_meta  [W+1];
  logic          dv_vld   [W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (ce) begin
      dv_vld[0] <= r_vld;
    end
    if (ce) begin
      dv_meta[0] <= r_meta;
    end
  end

  for (genvar j = 0; j < 2; j++) begin : g_lane
    always_ff @(posedge clk) begin
      if (ce) begin
        dv_rem[0][j]   <= {r_num[j], {F{1'b0}}};
        dv_den[0][j]   <= r_den[j];
        dv_q[0][j]     <= '0;
        dv_clamp[0][j] <= CW'({r_num[j], {F{1'b0}}}) >= (CW'(r_den[j]) << W);
      end
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k] <= 1'b0;
      end else if (ce) begin
        dv_vld[k] <= dv_vld[k-1];
      end
      if (ce) begin
        dv_meta[k] <= dv_meta[k-1];
      end
    end
    for (genvar j = 0; j < 2; j++) begin : g_dlane
      logic [CW-1:0] dsub;
      assign dsub = CW'(dv_den[k-1][j]) << (W-k);
      always_ff @(posedge clk) begin
        if (ce) begin
          dv_den[k][j]   <= dv_den[k-1][j];
          dv_clamp[k][j] <= dv_clamp[k-1][j];
          if (CW'(dv_rem[k-1][j]) >= dsub) begin
            dv_rem[k][j] <= dv_rem[k-1][j] - MW'(dsub);
            dv_q[k][j]   <= dv_q[k-1][j] | (W'(1) << (W-k));
          end else begin
            dv_rem[k][j] <= dv_rem[k-1][j];
            dv_q[k][j]   <= dv_q[k-1][j];
          end
        end
      end
    end
  end

  // select root, add start time, saturate
  function automatic logic [W-1:0] sat_add(logic signed [W-1:0] t, logic [QW-1:0] q);
    logic signed [W+1:0] s;
    logic signed [W+1:0] hi;
    hi = $signed({3'b000, {(W-1){1'b1}}});
    s  = (W+2)'(t) + $signed({1'b0, q});
    if (s > hi) begin
      sat_add = {1'b0, {(W-1){1'b1}}};
    end else begin
      sat_add = s[W-1:0];
    end
  endfunction

  logic [QW-1:0] qa, qb;
  meta_t         fm;
  logic          f_found;
  logic [W-1:0]  f_time;
  assign fm = dv_meta[W];
  assign qa = dv_clamp[W][0] ? (QW'(1) << W) : QW'(dv_q[W][0]);
  assign qb = dv_clamp[W][1] ? (QW'(1) << W) : QW'(dv_q[W][1]);

  always_comb begin
    f_found = 1'b0;
    f_time  = '0;
    if (fm.there) begin
      f_found = 1'b1;
      f_time  = fm.t;
    end else if (fm.lin) begin
      if (fm.lin_ok) begin
        f_found = 1'b1;
        f_time  = sat_add(fm.t, qa);
      end
    end else if (fm.ok) begin
      if (fm.nn1 && (!fm.nn2 || (qa < qb))) begin
        f_found = 1'b1;
        f_time  = sat_add(fm.t, qa);
      end else if (fm.nn2) begin
        f_found = 1'b1;
        f_time  = sat_add(fm.t, qb);
      end
    end
  end

  logic [W-1:0] arrival_time;
  logic         found;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ce) begin
      m_axis_tvalid <= dv_vld[W];
    end
    if (ce) begin
      found        <= f_found;
      arrival_time <= f_time;
    end
  end

  assign m_axis_tdata = OW'(arrival_time);
  assign m_axis_tuser = found;

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !found |-> arrival_time == '0)
    else $error("miss beat carries nonzero time");

  a_tol_write: assert property (@(posedge clk) disable iff (rst)
    tol_wr_en |=> tol == $past(tol_wr_data))
    else $error("tolerance write lost");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    sq_vld[SN] |-> sq_rem[SN] <= REMW'({sq_root[SN], 1'b0}))
    else $error("square root remainder out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dv_vld[W] && !dv_clamp[W][0] |-> dv_rem[W][0] < MW'(dv_den[W][0]))
    else $error("divider remainder not below divisor");

endmodule
